/* src/msq_pkg.sv */
// shared types, constants and tables of the midi step sequencer
`timescale 1ns / 1ps
`default_nettype none
package msq_pkg;

  // sequencer size and timing constants
  localparam int STEP_COUNT         = 16;
  localparam int PULSES_PER_QUARTER = 24;
  localparam int MIN_TEMPO          = 40;
  localparam int MAX_TEMPO          = 240;
  localparam int RESET_TEMPO        = 120;
  localparam int US_PER_MINUTE      = 60000000;
  localparam int STEPS_PER_BEAT     = 4;

  localparam int STEP_W = $clog2(STEP_COUNT);

  // dividends of the two intervals, so that each interval is one division by bpm
  localparam int STEP_DIVIDEND  = US_PER_MINUTE / STEPS_PER_BEAT;
  localparam int CLOCK_DIVIDEND = US_PER_MINUTE / PULSES_PER_QUARTER;
  localparam int DIVIDEND_MAX   =
      (STEP_DIVIDEND > CLOCK_DIVIDEND) ? STEP_DIVIDEND : CLOCK_DIVIDEND;
  localparam int DIV_W = $clog2(DIVIDEND_MAX + 1);

  // intervals after reset
  localparam int RESET_BPM_UP  = (RESET_TEMPO < MIN_TEMPO) ? MIN_TEMPO : RESET_TEMPO;
  localparam int RESET_BPM_CL  = (RESET_BPM_UP > MAX_TEMPO) ? MAX_TEMPO : RESET_BPM_UP;
  localparam int RESET_BPM     = (RESET_BPM_CL == 0) ? 1 : RESET_BPM_CL;
  localparam int RESET_STEP_IVL  = STEP_DIVIDEND / RESET_BPM;
  localparam int RESET_CLOCK_IVL = CLOCK_DIVIDEND / RESET_BPM;

  // command codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_PLAY      = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_REC_START = 3'd3;
  localparam logic [2:0] OP_REC_PAD   = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  // event kinds
  localparam logic [2:0] KIND_CLOCK    = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd2;
  localparam logic [2:0] KIND_START    = 3'd3;
  localparam logic [2:0] KIND_STOP     = 3'd4;
  localparam logic [2:0] KIND_ALL_OFF  = 3'd5;
  localparam int         KIND_COUNT    = 6;

  // run modes
  localparam logic [1:0] MODE_STOPPED   = 2'd0;
  localparam logic [1:0] MODE_PLAYING   = 2'd1;
  localparam logic [1:0] MODE_RECORDING = 2'd2;

  localparam logic [6:0] DEFAULT_VELOCITY = 7'd100;

  localparam logic [6:0] NOTE_TABLE [16] = '{
    7'd36, 7'd38, 7'd40, 7'd42, 7'd44, 7'd46, 7'd49, 7'd51,
    7'd41, 7'd43, 7'd45, 7'd47, 7'd48, 7'd50, 7'd52, 7'd55
  };

  // input item
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_us;
    logic [7:0]  pad_id;
    logic [6:0]  pad_velocity;
  } command_t;

  // result item
  typedef struct packed {
    logic [2:0] event_kind;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
    logic       last_event;
  } event_t;

  // one step of the pattern memory
  typedef struct packed {
    logic [6:0] note;
    logic [6:0] velocity;
    logic       active;
  } step_t;

  localparam int STEP_ENTRY_W = $bits(step_t);

  // intervals from the tempo divider
  typedef struct packed {
    logic [DIV_W-1:0] step_ivl;
    logic [DIV_W-1:0] clock_ivl;
  } interval_t;

endpackage
`default_nettype wire

/* src/msq_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/msq_tempo_div.sv */
// restoring divider that turns the tempo into step and clock intervals
`timescale 1ns / 1ps
`default_nettype none
module msq_tempo_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                go,
  input  wire logic [7:0]          bpm,
  output logic                     busy,
  output msq_pkg::interval_t       intervals
);

  localparam int CNT_W = $clog2(msq_pkg::DIV_W + 1);

  logic [CNT_W-1:0]         count;
  logic [7:0]               divisor;
  logic [7:0]               step_rem;
  logic [7:0]               clock_rem;
  logic [msq_pkg::DIV_W-1:0] step_quo;
  logic [msq_pkg::DIV_W-1:0] clock_quo;
  logic [7:0]               bpm_up;
  logic [7:0]               bpm_clamped;
  logic [7:0]               step_rem_next;
  logic [7:0]               clock_rem_next;
  logic [msq_pkg::DIV_W-1:0] step_quo_next;
  logic [msq_pkg::DIV_W-1:0] clock_quo_next;

  // one restoring step: shift in the next dividend bit, subtract when it fits
  function automatic logic [8:0] div_bit(input logic [7:0] rem, input logic msb,
                                         input logic [7:0] dvs);
    logic [8:0] trial;
    logic       fits;
    trial = {rem, msb};
    fits  = trial >= {1'b0, dvs};
    return fits ? {8'(trial - {1'b0, dvs}), 1'b1} : {trial[7:0], 1'b0};
  endfunction

  // clamp up to the minimum, then down to the maximum
  always_comb begin
    bpm_up      = (bpm < 8'(msq_pkg::MIN_TEMPO)) ? 8'(msq_pkg::MIN_TEMPO) : bpm;
    bpm_clamped = (bpm_up > 8'(msq_pkg::MAX_TEMPO)) ? 8'(msq_pkg::MAX_TEMPO) : bpm_up;
    if (bpm_clamped == 8'd0) begin
      bpm_clamped = 8'd1;
    end
  end

  // both quotients share the divisor and advance one bit a cycle
  always_comb begin
    {step_rem_next, step_quo_next[0]}   = div_bit(step_rem, step_quo[msq_pkg::DIV_W-1],
                                                  divisor);
    {clock_rem_next, clock_quo_next[0]} = div_bit(clock_rem, clock_quo[msq_pkg::DIV_W-1],
                                                  divisor);
    step_quo_next[msq_pkg::DIV_W-1:1]  = step_quo[msq_pkg::DIV_W-2:0];
    clock_quo_next[msq_pkg::DIV_W-1:1] = clock_quo[msq_pkg::DIV_W-2:0];
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy                <= 1'b0;
      count               <= '0;
      intervals.step_ivl  <= msq_pkg::DIV_W'(msq_pkg::RESET_STEP_IVL);
      intervals.clock_ivl <= msq_pkg::DIV_W'(msq_pkg::RESET_CLOCK_IVL);
    end else if (go) begin
      busy  <= 1'b1;
      count <= CNT_W'(msq_pkg::DIV_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy                <= 1'b0;
        intervals.step_ivl  <= step_quo_next;
        intervals.clock_ivl <= clock_quo_next;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (go) begin
      divisor   <= bpm_clamped;
      step_rem  <= '0;
      clock_rem <= '0;
      step_quo  <= msq_pkg::DIV_W'(msq_pkg::STEP_DIVIDEND);
      clock_quo <= msq_pkg::DIV_W'(msq_pkg::CLOCK_DIVIDEND);
    end else if (busy) begin
      step_rem  <= step_rem_next;
      clock_rem <= clock_rem_next;
      step_quo  <= step_quo_next;
      clock_quo <= clock_quo_next;
    end
  end

endmodule
`default_nettype wire

/* src/midi_step_sequencer.sv */
// top level of the midi step sequencer: command decode, tick sequencer, event output
// play and stop go from idle straight to emit; a tick passes eval, and a tick with step
// events then rd_cur and get_cur, before emit; then one event a cycle
// record, clear and ignored items return to idle at once; a tick makes two pattern ram
// reads; a tempo write holds busy until the divider is done; the receiver cannot stall
// reset: synchronous; the pattern reads as its defaults through per-step valid bits
`timescale 1ns / 1ps
`default_nettype none
module midi_step_sequencer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire msq_pkg::command_t command,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  output logic                   strobe,
  output msq_pkg::event_t        result
);

  localparam int SW = msq_pkg::STEP_W;
  localparam int KC = msq_pkg::KIND_COUNT;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EVAL    = 3'd1;
  localparam logic [2:0] ST_RD_CUR  = 3'd2;
  localparam logic [2:0] ST_GET_CUR = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0]              state;
  logic [1:0]              mode;
  logic [SW-1:0]           play_pos;
  logic [SW-1:0]           rec_pos;
  logic [31:0]             last_step;
  logic [31:0]             last_clock;
  logic [KC-1:0]           pend;
  logic [msq_pkg::STEP_COUNT-1:0] step_valid;
  logic                    clk_due_q;
  logic [31:0]             now_q;

  logic                    div_busy;
  msq_pkg::interval_t      intervals;

  logic                    accept;
  logic                    pad_write;
  logic [SW-1:0]           prev_pos;
  logic [SW-1:0]           rd_addr;
  logic [SW-1:0]           rd_addr_q;
  logic                    rd_valid_q;
  logic [msq_pkg::STEP_ENTRY_W-1:0] ram_rdata;
  msq_pkg::step_t          ram_wentry;
  msq_pkg::step_t          rd_entry;
  logic                    clk_due;
  logic                    step_due;
  logic                    prev_active;
  logic [6:0]              off_note;
  logic [6:0]              on_note;
  logic [6:0]              on_vel;
  logic [KC-1:0]           tick_pend;
  logic [2:0]              pick_kind;
  logic [KC-1:0]           pend_rest;
  msq_pkg::event_t         evt;

  assign busy   = (state != ST_IDLE) || div_busy;
  assign accept = start && !busy;

  // tempo divider, started by a register write
  msq_tempo_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (cfg_we),
    .bpm       (cfg_wdata),
    .busy      (div_busy),
    .intervals (intervals)
  );

  // pattern write from a recorded pad hit
  assign pad_write = accept && (command.op == msq_pkg::OP_REC_PAD) &&
                     (mode == msq_pkg::MODE_RECORDING) &&
                     (command.pad_id < 8'(msq_pkg::STEP_COUNT));

  always_comb begin
    ram_wentry.note     = msq_pkg::NOTE_TABLE[command.pad_id[3:0]];
    ram_wentry.velocity = command.pad_velocity;
    ram_wentry.active   = 1'b1;
  end

  // previous step wraps to the last one; read prev in eval, current after
  assign prev_pos = (play_pos == '0) ? SW'(msq_pkg::STEP_COUNT - 1) : play_pos - 1'b1;
  assign rd_addr  = (state == ST_EVAL) ? prev_pos : play_pos;

  msq_ram #(
    .WIDTH (msq_pkg::STEP_ENTRY_W),
    .DEPTH (msq_pkg::STEP_COUNT)
  ) u_pattern (
    .clk   (clk),
    .we    (pad_write),
    .waddr (rec_pos),
    .wdata (ram_wentry),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // a step never written since reset or clear reads as its default
  always_comb begin
    if (rd_valid_q) begin
      rd_entry = ram_rdata;
    end else begin
      rd_entry.note     = msq_pkg::NOTE_TABLE[4'(rd_addr_q)];
      rd_entry.velocity = msq_pkg::DEFAULT_VELOCITY;
      rd_entry.active   = 1'b0;
    end
  end

  // elapsed time checks, wrapping modulo 2^32
  assign clk_due  = (now_q - last_clock) >= 32'(intervals.clock_ivl);
  assign step_due = (now_q - last_step)  >= 32'(intervals.step_ivl);

  // events a tick leaves once both steps are read
  always_comb begin
    tick_pend                         = '0;
    tick_pend[msq_pkg::KIND_CLOCK]    = clk_due_q;
    tick_pend[msq_pkg::KIND_NOTE_OFF] = prev_active;
    tick_pend[msq_pkg::KIND_NOTE_ON]  = rd_entry.active;
  end

  // lowest pending kind goes out first
  always_comb begin
    pick_kind = msq_pkg::KIND_CLOCK;
    for (int k = KC - 1; k >= 0; k--) begin
      if (pend[k]) begin
        pick_kind = 3'(k);
      end
    end
    pend_rest = pend & ~(KC'(1) << pick_kind);
  end

  always_comb begin
    evt.event_kind    = pick_kind;
    evt.note_number   = 7'd0;
    evt.note_velocity = 7'd0;
    evt.last_event    = (pend_rest == '0);
    if (pick_kind == msq_pkg::KIND_NOTE_OFF) begin
      evt.note_number = off_note;
    end else if (pick_kind == msq_pkg::KIND_NOTE_ON) begin
      evt.note_number   = on_note;
      evt.note_velocity = on_vel;
    end
  end

  // sequencer control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= msq_pkg::MODE_STOPPED;
      play_pos   <= '0;
      rec_pos    <= '0;
      last_step  <= '0;
      last_clock <= '0;
      pend       <= '0;
      step_valid <= '0;
      clk_due_q  <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= (state == ST_EMIT);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (command.op)
              msq_pkg::OP_TICK: begin
                if (mode != msq_pkg::MODE_STOPPED) begin
                  state <= ST_EVAL;
                end
              end
              msq_pkg::OP_PLAY: begin
                if (mode == msq_pkg::MODE_STOPPED) begin
                  mode       <= msq_pkg::MODE_PLAYING;
                  play_pos   <= '0;
                  last_step  <= command.now_us;
                  last_clock <= command.now_us;
                  pend       <= KC'(1) << msq_pkg::KIND_START;
                  state      <= ST_EMIT;
                end
              end
              msq_pkg::OP_STOP: begin
                if (mode != msq_pkg::MODE_STOPPED) begin
                  mode     <= msq_pkg::MODE_STOPPED;
                  play_pos <= '0;
                  pend     <= (KC'(1) << msq_pkg::KIND_STOP) |
                              (KC'(1) << msq_pkg::KIND_ALL_OFF);
                  state    <= ST_EMIT;
                end
              end
              msq_pkg::OP_REC_START: begin
                mode    <= msq_pkg::MODE_RECORDING;
                rec_pos <= '0;
              end
              msq_pkg::OP_REC_PAD: begin
                if (pad_write) begin
                  step_valid[rec_pos] <= 1'b1;
                  rec_pos <= (rec_pos == SW'(msq_pkg::STEP_COUNT - 1)) ? '0 :
                             rec_pos + 1'b1;
                end
              end
              msq_pkg::OP_CLEAR: begin
                step_valid <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_EVAL: begin
          clk_due_q <= clk_due;
          if (clk_due) begin
            last_clock <= last_clock + 32'(intervals.clock_ivl);
          end
          if (step_due) begin
            last_step <= last_step + 32'(intervals.step_ivl);
            state     <= ST_RD_CUR;
          end else if (clk_due) begin
            pend  <= KC'(1) << msq_pkg::KIND_CLOCK;
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RD_CUR: begin
          state <= ST_GET_CUR;
        end
        ST_GET_CUR: begin
          play_pos <= (play_pos == SW'(msq_pkg::STEP_COUNT - 1)) ? '0 : play_pos + 1'b1;
          pend     <= tick_pend;
          state    <= (tick_pend == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          pend <= pend_rest;
          if (pend_rest == '0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers: timestamp, read tracking, step notes, result
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q <= command.now_us;
    end
    rd_addr_q  <= rd_addr;
    rd_valid_q <= step_valid[rd_addr];
    if (state == ST_RD_CUR) begin
      prev_active <= rd_entry.active;
      off_note    <= rd_entry.note;
    end
    if (state == ST_GET_CUR) begin
      on_note <= rd_entry.note;
      on_vel  <= rd_entry.velocity;
    end
    if (state == ST_EMIT) begin
      result <= evt;
    end
  end

endmodule
`default_nettype wire

/* sim/midi_step_sequencer_tb.sv */
// testbench of the midi step sequencer: directed and random commands checked against a predictor
`timescale 1ns / 1ps
module midi_step_sequencer_tb;

  // op codes the block must ignore
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  // settle time after the last event, and bound on waiting for events
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 27;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  msq_pkg::command_t command = '0;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = '0;
  logic              strobe;
  msq_pkg::event_t   result;

  midi_step_sequencer u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .strobe(strobe),
    .result(result)
  );

  // predicted sequencer state
  logic [6:0]  pat_note [msq_pkg::STEP_COUNT];
  logic [6:0]  pat_vel [msq_pkg::STEP_COUNT];
  logic        pat_on [msq_pkg::STEP_COUNT];
  logic [1:0]  seq_mode;
  int          play_pos;
  int          rec_pos;
  logic [31:0] step_mark;
  logic [31:0] clock_mark;
  logic [31:0] step_ivl;
  logic [31:0] clock_ivl;

  msq_pkg::event_t pending_events[$];
  int          mismatch_count = 0;
  logic [31:0] stamp_us;
  bit          steady;
  bit          last_acted;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("midi_step_sequencer test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] %s", $time, msg);
  endtask

  function automatic void restore_pattern();
    for (int i = 0; i < msq_pkg::STEP_COUNT; i++) begin
      pat_note[i] = msq_pkg::NOTE_TABLE[i % 16];
      pat_vel[i]  = msq_pkg::DEFAULT_VELOCITY;
      pat_on[i]   = 1'b0;
    end
  endfunction

  // clamp the tempo and derive both intervals
  function automatic void set_tempo(input logic [7:0] bpm_raw);
    int bpm;
    bpm = int'(bpm_raw);
    if (bpm < msq_pkg::MIN_TEMPO) bpm = msq_pkg::MIN_TEMPO;
    if (bpm > msq_pkg::MAX_TEMPO) bpm = msq_pkg::MAX_TEMPO;
    step_ivl  = msq_pkg::US_PER_MINUTE / bpm / msq_pkg::STEPS_PER_BEAT;
    clock_ivl = msq_pkg::US_PER_MINUTE / bpm / msq_pkg::PULSES_PER_QUARTER;
  endfunction

  function automatic void push_event(input logic [2:0] kind, input logic [6:0] note,
                                     input logic [6:0] vel);
    msq_pkg::event_t e;
    e.event_kind    = kind;
    e.note_number   = note;
    e.note_velocity = vel;
    e.last_event    = 1'b0;
    pending_events.push_back(e);
  endfunction

  // apply one command to the predicted state and queue the events it causes;
  // returns 0 when the sequencer ignores the command
  function automatic bit sequence_command(input msq_pkg::command_t c);
    logic [31:0]     since;
    int              cur;
    int              prev;
    int              base;
    bit              acted;
    msq_pkg::event_t tail;
    base  = pending_events.size();
    acted = 1'b1;
    case (c.op)
      msq_pkg::OP_TICK: begin
        if (seq_mode == msq_pkg::MODE_STOPPED) begin
          acted = 1'b0;
        end else begin
          since = c.now_us - clock_mark;
          if (since >= clock_ivl) begin
            clock_mark += clock_ivl;
            push_event(msq_pkg::KIND_CLOCK, '0, '0);
          end
          since = c.now_us - step_mark;
          if (since >= step_ivl) begin
            cur  = play_pos;
            prev = (cur == 0) ? msq_pkg::STEP_COUNT - 1 : cur - 1;
            step_mark += step_ivl;
            if (pat_on[prev]) push_event(msq_pkg::KIND_NOTE_OFF, pat_note[prev], '0);
            if (pat_on[cur]) push_event(msq_pkg::KIND_NOTE_ON, pat_note[cur], pat_vel[cur]);
            play_pos = (cur + 1) % msq_pkg::STEP_COUNT;
          end
        end
      end
      msq_pkg::OP_PLAY: begin
        if (seq_mode != msq_pkg::MODE_STOPPED) begin
          acted = 1'b0;
        end else begin
          seq_mode   = msq_pkg::MODE_PLAYING;
          play_pos   = 0;
          step_mark  = c.now_us;
          clock_mark = c.now_us;
          push_event(msq_pkg::KIND_START, '0, '0);
        end
      end
      msq_pkg::OP_STOP: begin
        if (seq_mode == msq_pkg::MODE_STOPPED) begin
          acted = 1'b0;
        end else begin
          seq_mode = msq_pkg::MODE_STOPPED;
          push_event(msq_pkg::KIND_STOP, '0, '0);
          push_event(msq_pkg::KIND_ALL_OFF, '0, '0);
          play_pos = 0;
        end
      end
      msq_pkg::OP_REC_START: begin
        seq_mode = msq_pkg::MODE_RECORDING;
        rec_pos  = 0;
      end
      msq_pkg::OP_REC_PAD: begin
        if (seq_mode != msq_pkg::MODE_RECORDING || c.pad_id >= msq_pkg::STEP_COUNT) begin
          acted = 1'b0;
        end else begin
          pat_note[rec_pos] = msq_pkg::NOTE_TABLE[c.pad_id[3:0]];
          pat_vel[rec_pos]  = c.pad_velocity;
          pat_on[rec_pos]   = 1'b1;
          rec_pos = (rec_pos + 1) % msq_pkg::STEP_COUNT;
        end
      end
      msq_pkg::OP_CLEAR: begin
        restore_pattern();
      end
      default: begin
        acted = 1'b0;
      end
    endcase
    // mark the final event of this item
    if (pending_events.size() > base) begin
      tail = pending_events.pop_back();
      tail.last_event = 1'b1;
      pending_events.push_back(tail);
    end
    return acted;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one item and hold it until the block takes it
  task automatic issue_command(input logic [2:0] op, input logic [31:0] now,
                               input logic [7:0] pad, input logic [6:0] vel);
    int                gap;
    msq_pkg::command_t c;
    c.op           = op;
    c.now_us       = now;
    c.pad_id       = pad;
    c.pad_velocity = vel;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy !== 1'b0);
    last_acted = sequence_command(c);
  endtask

  task automatic issue_plain(input logic [2:0] op);
    issue_command(op, $urandom, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  // stop sending and wait until every expected event is in and the block is quiet
  task automatic await_idle();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_events.size() != 0) begin
      report_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));
      pending_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_tempo(input logic [7:0] bpm);
    await_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= bpm;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_tempo(bpm);
    @(posedge clk);
  endtask

  // event check: every strobe must match the oldest expectation
  always @(posedge clk) begin : event_check
    msq_pkg::event_t want;
    if (!rst && strobe !== 1'b0) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d note %0d vel %0d last %0b",
                                  result.event_kind, result.note_number,
                                  result.note_velocity, result.last_event));
      end else begin
        want = pending_events.pop_front();
        if (strobe !== 1'b1 || result.event_kind !== want.event_kind ||
            result.note_number !== want.note_number ||
            result.note_velocity !== want.note_velocity ||
            result.last_event !== want.last_event)
          report_mismatch($sformatf({"event kind %0d note %0d vel %0d last %0b, ",
                                     "expected kind %0d note %0d vel %0d last %0b"},
                                    result.event_kind, result.note_number,
                                    result.note_velocity, result.last_event,
                                    want.event_kind, want.note_number,
                                    want.note_velocity, want.last_event));
      end
    end
  end

  // random item choice, steered by the predicted mode toward sequences that play
  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return (r == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    if (r < 5) return msq_pkg::OP_CLEAR;
    if (r < 9) return msq_pkg::OP_REC_START;
    case (seq_mode)
      msq_pkg::MODE_STOPPED: begin
        if (r < 60) return msq_pkg::OP_PLAY;
        if (r < 75) return msq_pkg::OP_REC_START;
        if (r < 85) return msq_pkg::OP_REC_PAD;
        if (r < 92) return msq_pkg::OP_TICK;
        return msq_pkg::OP_STOP;
      end
      msq_pkg::MODE_RECORDING: begin
        if (r < 38) return msq_pkg::OP_REC_PAD;
        if (r < 92) return msq_pkg::OP_TICK;
        if (r < 97) return msq_pkg::OP_STOP;
        return msq_pkg::OP_PLAY;
      end
      default: begin
        if (r < 90) return msq_pkg::OP_TICK;
        if (r < 95) return msq_pkg::OP_STOP;
        if (r < 97) return msq_pkg::OP_PLAY;
        return msq_pkg::OP_REC_PAD;
      end
    endcase
  endfunction

  // timestamps: steady progress, interval boundaries, big jumps and random values
  function automatic logic [31:0] pick_stamp(input logic [2:0] op);
    int r;
    if (op != msq_pkg::OP_TICK && op != msq_pkg::OP_PLAY) return $urandom;
    r = $urandom_range(0, 99);
    if (r < 5) stamp_us = $urandom;
    else if (r < 50) stamp_us += $urandom_range(0, clock_ivl);
    else if (r < 65) stamp_us = clock_mark + clock_ivl - $urandom_range(0, 1);
    else if (r < 80) stamp_us = step_mark + step_ivl - $urandom_range(0, 1);
    else stamp_us += $urandom_range(clock_ivl, 3 * step_ivl);
    return stamp_us;
  endfunction

  function automatic logic [7:0] pick_pad();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, msq_pkg::STEP_COUNT - 1));
  endfunction

  // commands that do nothing while stopped, and undefined codes
  task automatic test_idle_commands();
    issue_plain(msq_pkg::OP_TICK);
    issue_plain(msq_pkg::OP_STOP);
    issue_plain(OP_UNUSED_6);
    issue_plain(OP_UNUSED_7);
    issue_command(msq_pkg::OP_REC_PAD, $urandom, 8'd3, 7'd90);
  endtask

  // play emits start, a second play is ignored
  task automatic test_play_twice();
    issue_command(msq_pkg::OP_PLAY, 32'd1000, 8'd0, 7'd0);
    issue_command(msq_pkg::OP_PLAY, 32'd5000, 8'd0, 7'd0);
  endtask

  // pads at the field extremes, out-of-range pads ignored
  task automatic test_record_pads();
    issue_plain(msq_pkg::OP_REC_START);
    issue_command(msq_pkg::OP_REC_PAD, $urandom, 8'd0, 7'd0);
    issue_command(msq_pkg::OP_REC_PAD, $urandom, 8'd15, 7'd127);
    issue_command(msq_pkg::OP_REC_PAD, $urandom, 8'd16, 7'd50);
    issue_command(msq_pkg::OP_REC_PAD, $urandom, 8'd255, 7'd1);
    issue_command(msq_pkg::OP_REC_PAD, $urandom, 8'd7, 7'd64);
  endtask

  // interval edges, note off then note on, and a very late tick
  task automatic test_step_timing();
    logic [31:0] origin;
    origin = 32'h0012_3400;
    issue_plain(msq_pkg::OP_STOP);
    issue_command(msq_pkg::OP_PLAY, origin, 8'd0, 7'd0);
    issue_command(msq_pkg::OP_TICK, origin + clock_ivl - 1, 8'd0, 7'd0);
    issue_command(msq_pkg::OP_TICK, origin + clock_ivl, 8'd0, 7'd0);
    issue_command(msq_pkg::OP_TICK, origin + step_ivl, 8'd0, 7'd0);
    issue_command(msq_pkg::OP_TICK, origin + 2 * step_ivl, 8'd0, 7'd0);
    issue_command(msq_pkg::OP_TICK, origin + 40 * step_ivl, 8'd0, 7'd0);
  endtask

  // clear while playing keeps the mode but silences the pattern
  task automatic test_clear_while_playing();
    issue_plain(msq_pkg::OP_CLEAR);
    issue_command(msq_pkg::OP_TICK, step_mark + step_ivl, 8'd0, 7'd0);
    issue_plain(msq_pkg::OP_STOP);
  endtask

  // time differences across the 32-bit wrap, recording while running
  task automatic test_time_wrap();
    issue_command(msq_pkg::OP_PLAY, 32'hFFFF_FF00, 8'd0, 7'd0);
    issue_plain(msq_pkg::OP_REC_START);
    issue_command(msq_pkg::OP_REC_PAD, $urandom, 8'd12, 7'd127);
    issue_command(msq_pkg::OP_TICK, 32'hFFFF_FF00 + step_ivl, 8'd0, 7'd0);
  endtask

  task automatic run_random_phase(input logic [7:0] bpm);
    int         done;
    logic [2:0] op;
    write_tempo(bpm);
    steady = ($urandom_range(0, 3) == 0);
    done = 0;
    while (done < PHASE_ITEMS) begin
      op = pick_op();
      issue_command(op, pick_stamp(op), pick_pad(), 7'($urandom_range(0, 127)));
      if (last_acted) done++;
    end
    steady = 1'b0;
  endtask

  // random traffic under clamped, boundary and random tempos
  task automatic test_tempo_sweep();
    run_random_phase(8'd0);
    run_random_phase(8'd255);
    run_random_phase(8'd40);
    run_random_phase(8'd240);
    run_random_phase(8'd39);
    run_random_phase(8'd241);
    run_random_phase(8'($urandom_range(0, 255)));
    run_random_phase(8'd120);
  endtask

  initial begin
    restore_pattern();
    seq_mode   = msq_pkg::MODE_STOPPED;
    play_pos   = 0;
    rec_pos    = 0;
    step_mark  = '0;
    clock_mark = '0;
    set_tempo(8'(msq_pkg::RESET_TEMPO));
    stamp_us   = '0;
    steady     = 1'b0;
    last_acted = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_commands();
    test_play_twice();
    test_record_pads();
    test_step_timing();
    test_clear_while_playing();
    test_time_wrap();
    test_tempo_sweep();
    await_idle();
    if (mismatch_count == 0) begin
      $display("midi_step_sequencer test passed");
    end else begin
      $display("midi_step_sequencer test failed");
    end
    $finish;
  end

endmodule
